FILE: rtl/core/brl_pkg.sv
// Shared types for the Bresenham line rasterizer.
// Holds the controller/datapath command and status structs; no dependencies.
package brl_pkg;

  // Extra bits of the decision value above the coordinate width (sign and 2x growth)
  localparam int unsigned ERR_EXTRA_BITS = 3;

  typedef struct packed {
    logic load;   // capture endpoints and set up the walk
    logic step;   // advance to the next point
  } brl_cmd_t;

  typedef struct packed {
    logic last;   // current point is the final one of the line
  } brl_status_t;

endpackage

FILE: rtl/core/bresenham_line_rasterizer_top.sv
// Top level of the Bresenham line rasterizer.
// Instantiates brl_ctrl and brl_datapath; uses brl_pkg.
//
// A line command is taken when start is high and busy is low. The walk is set
// up at the accepting edge and the points follow from the next cycle on, one
// per cycle on pixel_x_o/pixel_y_o with pixel_valid_o high, the final one
// flagged by last_point_o. The next command can be taken in the cycle after
// the last point. Points are shown for exactly one cycle and the receiver
// cannot stall them; busy stays high until the last point is out.
module bresenham_line_rasterizer_top #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  pixel_valid_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_point_o
);
  import brl_pkg::*;

  brl_cmd_t    cmd;
  brl_status_t status;

  brl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .status_i      (status),
    .busy          (busy),
    .pixel_valid_o (pixel_valid_o),
    .cmd_o         (cmd)
  );

  brl_datapath #(
    .CoordW (COORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .status_o     (status),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_point_o (last_point_o)
  );

endmodule

FILE: rtl/core/brl_ctrl.sv
// Controller for the Bresenham line rasterizer.
// Sequences setup and walk of one line; uses brl_pkg.
module brl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  brl_pkg::brl_status_t  status_i,
  output logic                  busy,
  output logic                  pixel_valid_o,
  output brl_pkg::brl_cmd_t     cmd_o
);
  import brl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign pixel_valid_o = (state_q == ST_WALK);
  assign cmd_o.load    = (state_q == ST_IDLE) && start;
  assign cmd_o.step    = (state_q == ST_WALK) && !status_i.last;

endmodule

FILE: rtl/core/brl_datapath.sv
// Datapath for the Bresenham line rasterizer: endpoint setup, walk position,
// decision value and last-point compare. Uses brl_pkg.
module brl_datapath #(
  parameter int unsigned CoordW = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  brl_pkg::brl_cmd_t     cmd_i,
  input  logic [CoordW-1:0]     start_x_i,
  input  logic [CoordW-1:0]     start_y_i,
  input  logic [CoordW-1:0]     end_x_i,
  input  logic [CoordW-1:0]     end_y_i,
  output brl_pkg::brl_status_t  status_o,
  output logic [CoordW-1:0]     pixel_x_o,
  output logic [CoordW-1:0]     pixel_y_o,
  output logic                  last_point_o
);
  import brl_pkg::*;

  localparam int unsigned ErrW = CoordW + ERR_EXTRA_BITS;
  localparam int unsigned PadW = ErrW - CoordW - 1;

  logic [CoordW-1:0]      walk_x_q, walk_x_d, walk_y_q, walk_y_d;
  logic [CoordW-1:0]      major_end_q, major_end_d;
  logic [CoordW-1:0]      adx_q, adx_d, ady_q, ady_d;
  logic signed [ErrW-1:0] err_q, err_d;
  logic                   y_major_q, y_major_d, minor_up_q, minor_up_d;

  // setup signals
  logic signed [CoordW:0] dx, dy;
  logic [CoordW:0]        dx_abs, dy_abs;
  logic                   ym_new, fwd;
  logic signed [ErrW-1:0] two_adx_new, two_ady_new, adx_new_w, ady_new_w;

  // walk signals
  logic signed [ErrW-1:0] two_a, two_b;
  logic [CoordW-1:0]      major_cur, minor_cur, minor_next;
  logic                   minor_move;

  assign dx     = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
  assign dy     = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
  assign dx_abs = dx[CoordW] ? $unsigned(-dx) : $unsigned(dx);
  assign dy_abs = dy[CoordW] ? $unsigned(-dy) : $unsigned(dy);
  assign ym_new = dy_abs[CoordW-1:0] > dx_abs[CoordW-1:0];

  assign two_adx_new = $signed({{PadW{1'b0}}, dx_abs[CoordW-1:0], 1'b0});
  assign two_ady_new = $signed({{PadW{1'b0}}, dy_abs[CoordW-1:0], 1'b0});
  assign adx_new_w   = $signed({{(PadW+1){1'b0}}, dx_abs[CoordW-1:0]});
  assign ady_new_w   = $signed({{(PadW+1){1'b0}}, dy_abs[CoordW-1:0]});
  assign fwd         = ym_new ? !dy[CoordW] : !dx[CoordW];

  assign two_a = $signed({{PadW{1'b0}}, adx_q, 1'b0});
  assign two_b = $signed({{PadW{1'b0}}, ady_q, 1'b0});

  assign major_cur  = y_major_q ? walk_y_q : walk_x_q;
  assign minor_cur  = y_major_q ? walk_x_q : walk_y_q;
  // x-major steps minor on e >= 0, y-major on e > 0
  assign minor_move = y_major_q ? (!err_q[ErrW-1] && (err_q != '0)) : !err_q[ErrW-1];
  assign minor_next = minor_up_q ? minor_cur + 1'b1 : minor_cur - 1'b1;

  always_comb begin
    walk_x_d    = walk_x_q;
    walk_y_d    = walk_y_q;
    major_end_d = major_end_q;
    adx_d       = adx_q;
    ady_d       = ady_q;
    err_d       = err_q;
    y_major_d   = y_major_q;
    minor_up_d  = minor_up_q;
    if (cmd_i.load) begin
      adx_d      = dx_abs[CoordW-1:0];
      ady_d      = dy_abs[CoordW-1:0];
      y_major_d  = ym_new;
      minor_up_d = (dx[CoordW] && dy[CoordW]) ||
                   (!dx[CoordW] && (dx != '0) && !dy[CoordW] && (dy != '0));
      walk_x_d   = fwd ? start_x_i : end_x_i;
      walk_y_d   = fwd ? start_y_i : end_y_i;
      if (ym_new) begin
        major_end_d = fwd ? end_y_i : start_y_i;
        err_d       = two_adx_new - ady_new_w;
      end else begin
        major_end_d = fwd ? end_x_i : start_x_i;
        err_d       = two_ady_new - adx_new_w;
      end
    end else if (cmd_i.step) begin
      if (y_major_q) begin
        walk_y_d = walk_y_q + 1'b1;
        if (minor_move) begin
          walk_x_d = minor_next;
          err_d    = err_q + two_a - two_b;
        end else begin
          err_d    = err_q + two_a;
        end
      end else begin
        walk_x_d = walk_x_q + 1'b1;
        if (minor_move) begin
          walk_y_d = minor_next;
          err_d    = err_q + two_b - two_a;
        end else begin
          err_d    = err_q + two_b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      major_end_q <= '0;
      adx_q       <= '0;
      ady_q       <= '0;
      err_q       <= '0;
      y_major_q   <= 1'b0;
      minor_up_q  <= 1'b0;
    end else begin
      walk_x_q    <= walk_x_d;
      walk_y_q    <= walk_y_d;
      major_end_q <= major_end_d;
      adx_q       <= adx_d;
      ady_q       <= ady_d;
      err_q       <= err_d;
      y_major_q   <= y_major_d;
      minor_up_q  <= minor_up_d;
    end
  end

  assign status_o.last = (major_cur >= major_end_q);
  assign pixel_x_o     = walk_x_q;
  assign pixel_y_o     = walk_y_q;
  assign last_point_o  = status_o.last;

endmodule
